/* rtl/rtc3w_pkg.sv */
// ----------------------------------------------------------------------------
// rtc3w_pkg
// Types, codes and helpers for the three-wire RTC serial master.
// ----------------------------------------------------------------------------
package rtc3w_pkg;

   // Request operation codes (the unused code acts as a plain tick)
   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_READ  = 2'd1,
      OP_WRITE = 2'd2
   } op_type;

   localparam logic [7:0] CMD_WRITE_BASE = 8'h8c;
   localparam logic [7:0] CMD_READ_BIT   = 8'h01;
   localparam logic [7:0] HALF_RESET     = 8'd3;
   localparam logic [4:0] CMD_BITS       = 5'd8;
   localparam logic [4:0] FRAME_BITS     = 5'd16;

   // One request item
   typedef struct packed {
      logic [1:0] op;
      logic [2:0] field_index;
      logic [6:0] write_value;
      logic       io_in;
   } req_item_type;

   // One result item
   typedef struct packed {
      logic       chip_enable;
      logic       serial_clock;
      logic       io_out;
      logic       io_drive;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_value;
   } rsp_item_type;

   // Binary to BCD; divide by ten through a reciprocal (exact below 1024)
   function automatic logic [7:0] to_bcd(input logic [6:0] v);
      logic [17:0] prod;
      logic [3:0]  tens;
      logic [6:0]  ones;
      prod = {11'd0, v} * 18'd205;
      tens = prod[14:11];
      ones = v - 7'({3'd0, tens} * 7'd10);
      return {tens, 4'd0} + {1'b0, ones};
   endfunction

   // BCD to binary; an out-of-range nibble is passed through arithmetically
   function automatic logic [7:0] from_bcd(input logic [7:0] n);
      logic [7:0] tens_val;
      tens_val = {4'd0, n[7:4]} * 8'd10;
      return tens_val + {4'd0, n[3:0]};
   endfunction

endpackage

/* rtl/rtc3w_req_reg.sv */
// ----------------------------------------------------------------------------
// rtc3w_req_reg
// Input register: captures one request transfer and holds it until the
// sequencer consumes it.
// ----------------------------------------------------------------------------
module rtc3w_req_reg
   import rtc3w_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_item,
   input  logic         rsp_free,
   output logic         step,
   output req_item_type item
);

   logic         valid_ff, valid_in;
   req_item_type item_ff, item_in;
   logic         take;

   // Consume the held item whenever the result register can take its result
   assign step      = valid_ff & rsp_free;
   assign req_stall = valid_ff & ~rsp_free;
   assign take      = req_valid & ~req_stall;
   assign item      = item_ff;

   // Next occupancy and payload
   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (take) begin
         valid_in = 1'b1;
         item_in  = req_item;
      end else if (step) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

endmodule

/* rtl/rtc3w_seq.sv */
// ----------------------------------------------------------------------------
// rtc3w_seq
// Pin sequencer: holds the transfer state and the half-period register and
// advances one tick for every consumed request item.
// ----------------------------------------------------------------------------
module rtc3w_seq
   import rtc3w_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_write_enable,
   input  logic [7:0]   csr_write_data,
   input  logic         step,
   input  req_item_type item,
   output rsp_item_type result
);

   logic [7:0]  half_period_ff, half_period_in;
   logic        active_ff, active_in;
   logic        is_read_ff, is_read_in;
   logic [4:0]  bit_count_ff, bit_count_in;
   logic        phase_ff, phase_in;
   logic [7:0]  tick_count_ff, tick_count_in;
   logic [15:0] out_shift_ff, out_shift_in;
   logic [7:0]  in_shift_ff, in_shift_in;

   logic [7:0]  half;
   logic [7:0]  tick_inc;
   logic [7:0]  cmd;
   logic [4:0]  bit_next;
   logic        is_start;
   logic        done;
   logic [7:0]  rval;
   logic        drive;

   // Half-period register, written any time the enable is high
   always_comb begin
      half_period_in = csr_write_enable ? csr_write_data : half_period_ff;
   end

   // Zero half period behaves as one tick
   assign half     = (half_period_ff == 8'd0) ? 8'd1 : half_period_ff;
   assign tick_inc = tick_count_ff + 8'd1;
   assign is_start = (item.op == OP_READ) || (item.op == OP_WRITE);
   assign bit_next = bit_count_ff + 5'd1;

   // Next transfer state
   always_comb begin
      active_in     = active_ff;
      is_read_in    = is_read_ff;
      bit_count_in  = bit_count_ff;
      phase_in      = phase_ff;
      tick_count_in = tick_count_ff;
      out_shift_in  = out_shift_ff;
      in_shift_in   = in_shift_ff;
      done          = 1'b0;
      rval          = 8'd0;
      cmd           = CMD_WRITE_BASE - {4'd0, item.field_index, 1'b0};
      if (step) begin
         if (!active_ff) begin
            // Start: form command byte and load the frame
            if (is_start) begin
               is_read_in = (item.op == OP_READ);
               if (is_read_in) begin
                  cmd          = cmd + CMD_READ_BIT;
                  out_shift_in = {8'd0, cmd};
               end else begin
                  out_shift_in = {to_bcd(item.write_value), cmd};
               end
               in_shift_in   = 8'd0;
               bit_count_in  = 5'd0;
               phase_in      = 1'b0;
               tick_count_in = 8'd0;
               active_in     = 1'b1;
            end
         end else begin
            tick_count_in = tick_inc;
            if (tick_inc >= half) begin
               tick_count_in = 8'd0;
               if (!phase_ff) begin
                  // End of low half: sample the data pin in the read phase
                  if (is_read_ff && bit_count_ff >= CMD_BITS) begin
                     in_shift_in = {item.io_in, in_shift_ff[7:1]};
                  end
                  phase_in = 1'b1;
               end else begin
                  // End of high half: advance to the next bit
                  phase_in     = 1'b0;
                  out_shift_in = {1'b0, out_shift_ff[15:1]};
                  bit_count_in = bit_next;
                  if (bit_next >= FRAME_BITS) begin
                     active_in    = 1'b0;
                     done         = 1'b1;
                     bit_count_in = 5'd0;
                     if (is_read_ff) begin
                        rval = from_bcd(in_shift_ff);
                     end
                  end
               end
            end
         end
      end
   end

   // Pin levels after the tick
   assign drive = active_in & ~(is_read_in && bit_count_in >= CMD_BITS);

   always_comb begin
      result.chip_enable  = active_in;
      result.serial_clock = active_in & phase_in;
      result.io_drive     = drive;
      result.io_out       = drive & out_shift_in[0];
      result.busy_res     = active_in;
      result.done_res     = done;
      result.read_value   = rval;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff <= HALF_RESET;
         active_ff      <= 1'b0;
         is_read_ff     <= 1'b0;
         bit_count_ff   <= 5'd0;
         phase_ff       <= 1'b0;
         tick_count_ff  <= 8'd0;
         out_shift_ff   <= 16'd0;
         in_shift_ff    <= 8'd0;
      end else begin
         half_period_ff <= half_period_in;
         active_ff      <= active_in;
         is_read_ff     <= is_read_in;
         bit_count_ff   <= bit_count_in;
         phase_ff       <= phase_in;
         tick_count_ff  <= tick_count_in;
         out_shift_ff   <= out_shift_in;
         in_shift_ff    <= in_shift_in;
      end
   end

endmodule

/* rtl/rtc3w_rsp_reg.sv */
// ----------------------------------------------------------------------------
// rtc3w_rsp_reg
// Result register: holds one result item until the consumer takes it.
// ----------------------------------------------------------------------------
module rtc3w_rsp_reg
   import rtc3w_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  rsp_item_type result,
   output logic         rsp_free,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item
);

   logic         valid_ff, valid_in;
   rsp_item_type item_ff, item_in;

   // Free when empty or when the held result transfers this cycle
   assign rsp_free  = ~valid_ff | ~rsp_stall;
   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

   // Load a new result, drop a transferred one
   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (step) begin
         valid_in = 1'b1;
         item_in  = result;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

endmodule

/* rtl/three_wire_rtc_bcd_master.sv */
// A request transfer passes the input register, then the result register,
// before the earliest transfer of its result.
// Throughput: one request item per cycle, sustained while rsp_stall is low.
// Reset: synchronous, active high; clears the transfer state, both valid
// flags, and sets the half period to three ticks.
// ----------------------------------------------------------------------------
// three_wire_rtc_bcd_master
// Three-wire serial master for a real-time-clock chip; each request item
// is one tick of the pin sequencer and yields one pin-level result.
// ----------------------------------------------------------------------------
module three_wire_rtc_bcd_master
   import rtc3w_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_op,
   input  logic [2:0] req_field_index,
   input  logic [6:0] req_write_value,
   input  logic       req_io_in,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_chip_enable,
   output logic       rsp_serial_clock,
   output logic       rsp_io_out,
   output logic       rsp_io_drive,
   output logic       rsp_busy_res,
   output logic       rsp_done_res,
   output logic [7:0] rsp_read_value
);

   req_item_type req_item;
   req_item_type item;
   rsp_item_type result;
   rsp_item_type rsp_item;
   logic         step;
   logic         rsp_free;

   // Gather request fields
   always_comb begin
      req_item.op          = req_op;
      req_item.field_index = req_field_index;
      req_item.write_value = req_write_value;
      req_item.io_in       = req_io_in;
   end

   rtc3w_req_reg u_req_reg (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_free  (rsp_free),
      .step      (step),
      .item      (item)
   );

   rtc3w_seq u_seq (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .step             (step),
      .item             (item),
      .result           (result)
   );

   rtc3w_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .result    (result),
      .rsp_free  (rsp_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   // Spread result fields onto ports
   assign rsp_chip_enable  = rsp_item.chip_enable;
   assign rsp_serial_clock = rsp_item.serial_clock;
   assign rsp_io_out       = rsp_item.io_out;
   assign rsp_io_drive     = rsp_item.io_drive;
   assign rsp_busy_res     = rsp_item.busy_res;
   assign rsp_done_res     = rsp_item.done_res;
   assign rsp_read_value   = rsp_item.read_value;

endmodule

/* rtl/rtc3w_checker.sv */
// ----------------------------------------------------------------------------
// rtc3w_checker
// Port-level checks on the result channel of the three-wire master.
// ----------------------------------------------------------------------------
module rtc3w_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_chip_enable,
   input logic       rsp_serial_clock,
   input logic       rsp_io_out,
   input logic       rsp_io_drive,
   input logic       rsp_busy_res,
   input logic       rsp_done_res,
   input logic [7:0] rsp_read_value
);

   // Released data pin is never driven high
   a_io_released: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_io_drive |-> !rsp_io_out)
      else $error("io_out high while io_drive low");

   // Idle bus: clock low and data pin released
   a_idle_pins: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_chip_enable |-> !rsp_serial_clock && !rsp_io_drive)
      else $error("pins active without chip enable");

   // Completion ends the transfer on the same tick
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_busy_res && !rsp_chip_enable)
      else $error("done while still busy");

   // Read value only appears on the completion tick
   a_value_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_done_res |-> rsp_read_value == 8'd0)
      else $error("read value outside completion");

   // Stalled result holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_read_value))
      else $error("stalled result changed");

endmodule

bind three_wire_rtc_bcd_master rtc3w_checker u_rtc3w_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_chip_enable  (rsp_chip_enable),
   .rsp_serial_clock (rsp_serial_clock),
   .rsp_io_out       (rsp_io_out),
   .rsp_io_drive     (rsp_io_drive),
   .rsp_busy_res     (rsp_busy_res),
   .rsp_done_res     (rsp_done_res),
   .rsp_read_value   (rsp_read_value)
);

/* tb/three_wire_rtc_bcd_master_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// three_wire_rtc_bcd_master_test
// Self-checking bench for the three-wire RTC master. Every accepted tick
// is run through a tick-level model of the pin sequencer. Each result
// transfer is compared field by field against the oldest predicted pin
// set. Directed frames cover the extreme fields and the corner cases;
// random ticks follow at several half-period settings, with bursty
// requests and patterned result stalls.
// ----------------------------------------------------------------------------
module three_wire_rtc_bcd_master_test;
   import rtc3w_pkg::*;

   // Unused op code, handled as a plain tick
   localparam logic [1:0] OP_SPARE = 2'd3;

   typedef enum int {IO_RANDOM, IO_ONES, IO_ZEROS} io_pattern_type;
   typedef enum int {STALL_NONE, STALL_SPARSE, STALL_PERIODIC, STALL_HEAVY} stall_mode_type;

   // Pin sequencer model and queue of predicted pin levels
   class pin_level_scoreboard;
      logic [7:0]   half_ticks;
      logic         active;
      logic         reading;
      logic [4:0]   bit_index;
      logic         high_half;
      logic [7:0]   tick_count;
      logic [15:0]  frame_shift;
      logic [7:0]   captured;
      rsp_item_type expected_pins[$];
      int           mismatches;

      function new();
         half_ticks = HALF_RESET;
         active = 1'b0;
         reading = 1'b0;
         bit_index = '0;
         high_half = 1'b0;
         tick_count = '0;
         frame_shift = '0;
         captured = '0;
         mismatches = 0;
      endfunction

      function int ticks_per_half();
         return (half_ticks == 8'd0) ? 1 : int'(half_ticks);
      endfunction

      // Advance the sequencer by one accepted tick and queue its pin levels
      function void note_request(req_item_type item);
         rsp_item_type pins;
         logic [7:0]   command;
         logic [7:0]   bcd;
         int           wv;
         pins = '0;
         if (!active) begin
            if (item.op == OP_READ || item.op == OP_WRITE) begin
               reading = (item.op == OP_READ);
               command = CMD_WRITE_BASE - {4'd0, item.field_index, 1'b0};
               if (reading)
                  command = command + CMD_READ_BIT;
               wv = int'(item.write_value);
               bcd = 8'((wv / 10) * 16 + wv % 10);
               frame_shift = reading ? {8'd0, command} : {bcd, command};
               captured = '0;
               bit_index = '0;
               high_half = 1'b0;
               tick_count = '0;
               active = 1'b1;
            end
         end else begin
            tick_count = tick_count + 8'd1;
            if (int'(tick_count) >= ticks_per_half()) begin
               tick_count = '0;
               if (!high_half) begin
                  // sample the data pin at the end of the low half
                  if (reading && bit_index >= CMD_BITS)
                     captured = {item.io_in, captured[7:1]};
                  high_half = 1'b1;
               end else begin
                  high_half = 1'b0;
                  frame_shift = frame_shift >> 1;
                  bit_index = bit_index + 5'd1;
                  if (bit_index >= FRAME_BITS) begin
                     active = 1'b0;
                     pins.done_res = 1'b1;
                     if (reading)
                        pins.read_value = 8'(int'(captured[7:4]) * 10 + int'(captured[3:0]));
                     bit_index = '0;
                  end
               end
            end
         end
         if (active) begin
            pins.chip_enable = 1'b1;
            pins.serial_clock = high_half;
            pins.io_drive = !(reading && bit_index >= CMD_BITS);
            pins.io_out = pins.io_drive & frame_shift[0];
            pins.busy_res = 1'b1;
         end
         expected_pins.push_back(pins);
      endfunction

      function void compare_field(string name, int want, int got);
         if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
         end
      endfunction

      // Compare one result transfer with the oldest prediction
      function void check_result(rsp_item_type got);
         rsp_item_type want;
         if (expected_pins.size() == 0) begin
            $error("result transfer with no prediction pending");
            mismatches++;
            return;
         end
         want = expected_pins.pop_front();
         compare_field("chip_enable", want.chip_enable, got.chip_enable);
         compare_field("serial_clock", want.serial_clock, got.serial_clock);
         compare_field("io_out", want.io_out, got.io_out);
         compare_field("io_drive", want.io_drive, got.io_drive);
         compare_field("busy_res", want.busy_res, got.busy_res);
         compare_field("done_res", want.done_res, got.done_res);
         compare_field("read_value", want.read_value, got.read_value);
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_write_enable = 1'b0;
   logic [7:0] csr_write_data = '0;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_op = OP_TICK;
   logic [2:0] req_field_index = '0;
   logic [6:0] req_write_value = '0;
   logic       req_io_in = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_chip_enable;
   logic       rsp_serial_clock;
   logic       rsp_io_out;
   logic       rsp_io_drive;
   logic       rsp_busy_res;
   logic       rsp_done_res;
   logic [7:0] rsp_read_value;

   pin_level_scoreboard sb;
   int                  burst_left = 0;
   stall_mode_type      stall_mode = STALL_NONE;
   int                  stall_left = 0;
   int                  stall_phase = 0;

   three_wire_rtc_bcd_master dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_field_index  (req_field_index),
      .req_write_value  (req_write_value),
      .req_io_in        (req_io_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_chip_enable  (rsp_chip_enable),
      .rsp_serial_clock (rsp_serial_clock),
      .rsp_io_out       (rsp_io_out),
      .rsp_io_drive     (rsp_io_drive),
      .rsp_busy_res     (rsp_busy_res),
      .rsp_done_res     (rsp_done_res),
      .rsp_read_value   (rsp_read_value)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Watch both channels at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.note_request(req_item_type'({req_op, req_field_index,
                                            req_write_value, req_io_in}));
         if (rsp_valid && !rsp_stall)
            sb.check_result(rsp_item_type'({rsp_chip_enable, rsp_serial_clock,
                                            rsp_io_out, rsp_io_drive, rsp_busy_res,
                                            rsp_done_res, rsp_read_value}));
      end
   end

   // Stall results on a pattern that switches mode now and then
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         stall_left = $urandom_range(40, 200);
      end
      stall_left--;
      stall_phase++;
      case (stall_mode)
         STALL_NONE:     rsp_stall <= 1'b0;
         STALL_SPARSE:   rsp_stall <= ($urandom_range(0, 4) == 0);
         STALL_PERIODIC: rsp_stall <= (stall_phase % 5 < 2);
         default:        rsp_stall <= ($urandom_range(0, 9) < 7);
      endcase
   end

   function automatic req_item_type make_item(logic [1:0] op, io_pattern_type pattern);
      req_item_type item;
      item.op = op;
      item.field_index = 3'($urandom_range(0, 7));
      item.write_value = 7'($urandom_range(0, 127));
      case (pattern)
         IO_ONES:  item.io_in = 1'b1;
         IO_ZEROS: item.io_in = 1'b0;
         default:  item.io_in = 1'($urandom_range(0, 1));
      endcase
      return item;
   endfunction

   function automatic req_item_type random_item();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 80)
         return make_item(OP_TICK, IO_RANDOM);
      else if (pick < 89)
         return make_item(OP_READ, IO_RANDOM);
      else if (pick < 98)
         return make_item(OP_WRITE, IO_RANDOM);
      return make_item(OP_SPARE, IO_RANDOM);
   endfunction

   // Present one item from a falling edge and hold it until the transfer;
   // open a random gap whenever a burst runs out
   task automatic drive_req(input req_item_type item);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 48);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      {req_op, req_field_index, req_write_value, req_io_in} <= item;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      @(negedge clock);
   endtask

   // Send a start, then ticks up to and including the done tick
   task automatic run_transfer(input logic [1:0] op, input logic [2:0] index,
                               input logic [6:0] value, input io_pattern_type pattern,
                               input logic [1:0] last_op);
      req_item_type item;
      int           ticks;
      item = make_item(op, pattern);
      item.field_index = index;
      item.write_value = value;
      ticks = 2 * int'(FRAME_BITS) * sb.ticks_per_half();
      drive_req(item);
      repeat (ticks - 1)
         drive_req(make_item(OP_TICK, pattern));
      drive_req(make_item(last_op, pattern));
   endtask

   task automatic finish_transfer(input io_pattern_type pattern);
      while (sb.active)
         drive_req(make_item(OP_TICK, pattern));
   endtask

   task automatic random_items(input int count);
      repeat (count)
         drive_req(random_item());
   endtask

   // Drop valid and hold until every predicted result has arrived
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_pins.size() != 0)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_half(input logic [7:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      sb.half_ticks = value;
   endtask

   initial begin
      req_item_type item;
      sb = new();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // plain ticks while idle, including the spare op code
      drive_req(make_item(OP_TICK, IO_ONES));
      drive_req(make_item(OP_SPARE, IO_ZEROS));

      // write at the reset half period; a read start on the done tick is dropped
      run_transfer(OP_WRITE, 3'd0, 7'd0, IO_RANDOM, OP_READ);

      // read of index seven, half period shortened in the low half of the first data bit
      item = make_item(OP_READ, IO_ONES);
      item.field_index = 3'd7;
      drive_req(item);
      repeat (50)
         drive_req(make_item(OP_TICK, IO_ONES));
      drain_results();
      write_half(8'd1);
      finish_transfer(IO_ONES);

      // fastest clock: extreme values, index seven, oversized write value
      run_transfer(OP_WRITE, 3'd6, 7'd99, IO_RANDOM, OP_TICK);
      run_transfer(OP_WRITE, 3'd7, 7'd127, IO_RANDOM, OP_SPARE);
      run_transfer(OP_READ, 3'd0, 7'd0, IO_ZEROS, OP_WRITE);
      run_transfer(OP_READ, 3'd4, 7'd85, IO_RANDOM, OP_TICK);
      run_transfer(OP_WRITE, 3'd5, 7'd100, IO_RANDOM, OP_TICK);
      random_items(30);
      finish_transfer(IO_RANDOM);
      drain_results();
      random_items(10);

      // zero half period acts as one tick
      finish_transfer(IO_RANDOM);
      drain_results();
      write_half(8'd0);
      random_items(30);

      finish_transfer(IO_RANDOM);
      drain_results();
      write_half(8'd2);
      random_items(20);

      // slower clock: a single read frame
      finish_transfer(IO_RANDOM);
      drain_results();
      write_half(8'd3);
      run_transfer(OP_READ, 3'd2, 7'($urandom_range(0, 127)), IO_RANDOM, OP_TICK);

      drain_results();
      write_half(8'($urandom_range(2, 3)));
      random_items(20);
      finish_transfer(IO_RANDOM);

      drain_results();
      repeat (10) @(posedge clock);
      if (sb.mismatches == 0 && sb.expected_pins.size() == 0)
         $display("PASS three_wire_rtc_bcd_master");
      else
         $display("FAIL three_wire_rtc_bcd_master");
      $finish;
   end

   // Watchdog
   initial begin
      #5000000;
      $display("FAIL three_wire_rtc_bcd_master");
      $finish;
   end

endmodule
